// ===== rtl/wtsp_pkg.sv =====
`timescale 1ns / 1ps

package wtsp_pkg;

  // data path widths
  localparam int DATA_W        = 32;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int FRAC_BITS_DEF = 16;

  // viewport sum width: 14-bit coefficient times 32-bit value plus offset
  localparam int VP_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] VIEWPORT_WIDTH_RST  = 14'd1920;
  localparam logic [CFG_DATA_W-1:0] VIEWPORT_HEIGHT_RST = 14'd1080;

  // item kinds
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  // saturation limits
  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;

endpackage

// ===== rtl/wtsp_mul.sv =====
`timescale 1ns / 1ps

module wtsp_mul
  import wtsp_pkg::*;
(
  input  logic  clk,
  input  logic  en,
  input  data_t a,
  input  data_t b,
  output prod_t prod
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

// ===== rtl/wtsp_div.sv =====
`timescale 1ns / 1ps

module wtsp_div
  import wtsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int ACC_W     = 66 - FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic signed [ACC_W-1:0] den,
  output logic                    busy,
  output logic                    done,
  output data_t                   quot
);

  localparam int IntBits = DATA_W - FRAC_BITS;

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_CHK  = 2'd1;
  localparam logic [1:0] D_RUN  = 2'd2;

  logic [1:0]        dstate;
  logic              neg;
  logic [ACC_W-1:0]  rem;
  logic [ACC_W-1:0]  dvs;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] q;
  logic [4:0]        cnt;

  logic [ACC_W-1:0]  mag;
  logic [ACC_W-1:0]  trial;
  logic              take;
  logic [DATA_W-1:0] q_next;
  data_t             q_sat;

  // magnitude of the dividend
  assign mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);

  // one restoring step: bring down the next dividend bit
  assign trial  = {rem[ACC_W-2:0], lo[DATA_W-1]};
  assign take   = (trial >= dvs);
  assign q_next = {q[DATA_W-2:0], take};

  // signed result with saturation to 32 bits
  always_comb begin
    if (neg) begin
      q_sat = (q_next > 32'h8000_0000) ? SAT_MIN : data_t'(~q_next + 32'd1);
    end else begin
      q_sat = q_next[DATA_W-1] ? SAT_MAX : data_t'(q_next);
    end
  end

  assign busy = (dstate != D_IDLE);

  // sequencer: overflow check, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            neg    <= num[ACC_W-1];
            rem    <= mag >> IntBits;
            lo     <= {mag[IntBits-1:0], {FRAC_BITS{1'b0}}};
            dvs    <= ACC_W'(den);
            dstate <= D_CHK;
          end
        end
        D_CHK: begin
          // quotient of 2^32 or more saturates at once
          if (rem >= dvs) begin
            quot   <= neg ? SAT_MIN : SAT_MAX;
            done   <= 1'b1;
            dstate <= D_IDLE;
          end else begin
            q      <= '0;
            cnt    <= '0;
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= take ? (trial - dvs) : trial;
          lo  <= {lo[DATA_W-2:0], 1'b0};
          q   <= q_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            quot   <= q_sat;
            done   <= 1'b1;
            dstate <= D_IDLE;
          end
        end
        default: begin
          dstate <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/world_to_screen_projection_core.sv =====
`timescale 1ns / 1ps
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-------------------------------------------------
// input    | in_valid  | in_stall  | mode, element_index, element_value, point_x/y/z
// output   | out_valid | out_stall | visible, screen_x, screen_y
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// load item: written to the matrix store, core stays free; visible point: clip sums, then the
// 32-step divider run for x and for y (quotients of 2^32 or more skip it), then viewport sums;
// hidden point: nine products on the shared multiplier plus adds
// rst is synchronous: matrix cleared to zero, viewport set to 1920 x 1080
// in_stall is high while a point is in work; the result sits in an output register,
// so a stalled output holds the core only when the next result is ready

module world_to_screen_projection_core
  import wtsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  mode,
  input  logic [3:0]            element_index,
  input  data_t                 element_value,
  input  data_t                 point_x,
  input  data_t                 point_y,
  input  data_t                 point_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  visible,
  output data_t                 screen_x,
  output data_t                 screen_y
);

  localparam int AccW   = 66 - FRAC_BITS;
  localparam int Thresh = ((1 << FRAC_BITS) + 5) / 10;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL       = 4'd1;
  localparam logic [3:0] S_ACC       = 4'd2;
  localparam logic [3:0] S_DIVX_GO   = 4'd3;
  localparam logic [3:0] S_DIVX_WAIT = 4'd4;
  localparam logic [3:0] S_DIVY_GO   = 4'd5;
  localparam logic [3:0] S_DIVY_WAIT = 4'd6;
  localparam logic [3:0] S_VXMUL     = 4'd7;
  localparam logic [3:0] S_VXSUM     = 4'd8;
  localparam logic [3:0] S_VYMUL     = 4'd9;
  localparam logic [3:0] S_VYSUM     = 4'd10;
  localparam logic [3:0] S_DONE      = 4'd11;

  function automatic data_t sat_vp(input logic signed [VP_W-1:0] v);
    if (v > VP_W'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < VP_W'(SAT_MIN)) begin
      return SAT_MIN;
    end else begin
      return data_t'(v[DATA_W-1:0]);
    end
  endfunction

  logic [3:0] state;
  logic [1:0] row;
  logic [1:0] col;

  logic [CFG_DATA_W-1:0] vp_width;
  logic [CFG_DATA_W-1:0] vp_height;

  data_t mat [16];

  data_t px, py, pz;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] cx, cy, cw;
  data_t nx, ny;
  logic  res_vis;
  data_t res_x, res_y;

  logic in_xfer;
  logic out_free;

  logic [1:0] mrow;
  logic [3:0] maddr;
  data_t      mval;

  logic  mul_en;
  data_t mul_a, mul_b;
  prod_t mul_prod;
  prod_t prod_sh;

  logic signed [AccW-1:0] acc_prod;
  logic signed [AccW-1:0] acc_trans;
  logic signed [VP_W-1:0] vp_sum;

  logic [12:0] half_w, half_h;
  data_t       coef_x, coef_y;

  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  data_t                  div_quot;
  logic signed [AccW-1:0] div_num;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vp_width  <= VIEWPORT_WIDTH_RST;
      vp_height <= VIEWPORT_HEIGHT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_VIEWPORT_WIDTH) begin
        vp_width <= cfg_data;
      end else if (cfg_index == REG_VIEWPORT_HEIGHT) begin
        vp_height <= cfg_data;
      end
    end
  end

  // matrix store, written by load items
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= '0;
      end
    end else if (in_xfer && mode == MODE_LOAD) begin
      mat[element_index] <= element_value;
    end
  end

  // single read port: clip rows 0, 1 and 3
  assign mrow  = (row == 2'd2) ? 2'd3 : row;
  assign maddr = {mrow, col};
  assign mval  = mat[maddr];

  // viewport coefficients: (W/2 + 1) and (1 - H/2)
  assign half_w = vp_width[CFG_DATA_W-1:1];
  assign half_h = vp_height[CFG_DATA_W-1:1];
  assign coef_x = data_t'({19'd0, half_w} + 32'd1);
  assign coef_y = data_t'(32'd1 - {19'd0, half_h});

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = mval;
    mul_b  = px;
    unique case (state)
      S_MUL: begin
        mul_en = 1'b1;
        mul_a  = mval;
        unique case (col)
          2'd0:    mul_b = px;
          2'd1:    mul_b = py;
          default: mul_b = pz;
        endcase
      end
      S_VXMUL: begin
        mul_en = 1'b1;
        mul_a  = coef_x;
        mul_b  = nx;
      end
      S_VYMUL: begin
        mul_en = 1'b1;
        mul_a  = coef_y;
        mul_b  = ny;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  wtsp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  // floor shift of the product and the running clip sums
  assign prod_sh   = mul_prod >>> FRAC_BITS;
  assign acc_prod  = acc + prod_sh[AccW-1:0];
  assign acc_trans = acc + {{(AccW - DATA_W){mval[DATA_W-1]}}, mval};

  // viewport offset sum on the registered product
  always_comb begin
    if (state == S_VXSUM) begin
      vp_sum = mul_prod[VP_W-1:0] + (VP_W'(half_w) << FRAC_BITS);
    end else begin
      vp_sum = mul_prod[VP_W-1:0] + (VP_W'(half_h) << FRAC_BITS);
    end
  end

  // divider shared by both coordinates
  assign div_start = (state == S_DIVX_GO) || (state == S_DIVY_GO);
  assign div_num   = (state == S_DIVX_GO) ? cx : cy;

  wtsp_div #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (AccW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (cw),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      row   <= '0;
      col   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer && mode == MODE_PROJECT) begin
            px    <= point_x;
            py    <= point_y;
            pz    <= point_z;
            acc   <= '0;
            row   <= '0;
            col   <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (col == 2'd3) begin
            // translation term closes the row
            acc <= '0;
            col <= '0;
            row <= row + 2'd1;
            unique case (row)
              2'd0: begin
                cx    <= acc_trans;
                state <= S_MUL;
              end
              2'd1: begin
                cy    <= acc_trans;
                state <= S_MUL;
              end
              default: begin
                cw <= acc_trans;
                if (acc_trans >= AccW'(Thresh)) begin
                  state <= S_DIVX_GO;
                end else begin
                  res_vis <= 1'b0;
                  res_x   <= '0;
                  res_y   <= '0;
                  state   <= S_DONE;
                end
              end
            endcase
          end else begin
            acc <= acc_prod;
            col <= col + 2'd1;
            state <= (col == 2'd2) ? S_ACC : S_MUL;
          end
        end
        S_DIVX_GO: begin
          state <= S_DIVX_WAIT;
        end
        S_DIVX_WAIT: begin
          if (div_done) begin
            nx    <= div_quot;
            state <= S_DIVY_GO;
          end
        end
        S_DIVY_GO: begin
          state <= S_DIVY_WAIT;
        end
        S_DIVY_WAIT: begin
          if (div_done) begin
            ny    <= div_quot;
            state <= S_VXMUL;
          end
        end
        S_VXMUL: begin
          state <= S_VXSUM;
        end
        S_VXSUM: begin
          res_x <= sat_vp(vp_sum);
          state <= S_VYMUL;
        end
        S_VYMUL: begin
          state <= S_VYSUM;
        end
        S_VYSUM: begin
          res_y   <= sat_vp(vp_sum);
          res_vis <= 1'b1;
          state   <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      visible  <= res_vis;
      screen_x <= res_x;
      screen_y <= res_y;
    end
  end

  // divider is only started when free
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_busy)
    else $error("divider started while busy");

  // a divider result only arrives while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVX_WAIT || state == S_DIVY_WAIT))
    else $error("divider result with no waiting sequencer");

  // a project transfer makes the core busy on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_xfer && mode == MODE_PROJECT) |=> in_stall)
    else $error("core not busy after project transfer");

  // a hidden point reports zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !visible) |-> (screen_x == '0 && screen_y == '0))
    else $error("hidden point with nonzero coordinates");

endmodule
